// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the expression evaluator.
// Depends on nothing; the checks vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/iee_pkg.sv
// Shared types and constants of the integer expression evaluator.
// Used by the iterative multiply/divide unit and by the top level.
package iee_pkg;

   localparam int VALUE_WIDTH   = 32;
   localparam int RESULT_WIDTH  = 32;
   localparam int OPERAND_WIDTH = 31;
   localparam int COMMAND_WIDTH = 3;
   localparam int STATUS_WIDTH  = 2;
   localparam int CNT_WIDTH     = $clog2(VALUE_WIDTH);

   typedef enum logic [COMMAND_WIDTH-1:0] {
      CMD_OPERAND = 3'd0,
      CMD_ADD     = 3'd1,
      CMD_SUB     = 3'd2,
      CMD_MUL     = 3'd3,
      CMD_DIV     = 3'd4,
      CMD_END     = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK        = 2'd0,
      ST_DIVZERO   = 2'd1,
      ST_MALFORMED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_MUL  = 2'd1,
      OP_DIV  = 2'd2
   } mulop_type;

   typedef struct packed {
      logic                   start;
      logic                   is_div;
      logic [VALUE_WIDTH-1:0] a;
      logic [VALUE_WIDTH-1:0] b;
   } unit_req_type;

   typedef struct packed {
      logic                   done;
      logic [VALUE_WIDTH-1:0] value;
   } unit_rsp_type;

endpackage

// File: hw/rtl/iee_muldiv.sv
// Iterative multiply/divide unit: one bit per cycle through one shared adder.
// Depends on iee_pkg for widths and the request/response structs.
module iee_muldiv (
   input  logic                 clock,
   input  logic                 reset,
   input  iee_pkg::unit_req_type unit_req,
   output iee_pkg::unit_rsp_type unit_rsp
);
   import iee_pkg::*;

   typedef enum logic [1:0] {U_IDLE, U_RUN, U_FIN} ustate_type;

   ustate_type             state_ff, state_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic                   is_div_ff, is_div_in;
   logic                   negate_ff, negate_in;
   logic                   done_ff, done_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic [VALUE_WIDTH-1:0] work_ff, work_in;
   logic [VALUE_WIDTH-1:0] opd_ff, opd_in;

   logic [VALUE_WIDTH-1:0] a_mag, b_mag, rem_shift, add_x, add_y;
   logic [VALUE_WIDTH:0]   add_sum;
   logic                   ge;

   assign a_mag = unit_req.a[VALUE_WIDTH-1] ? (~unit_req.a + VALUE_WIDTH'(1)) : unit_req.a;
   assign b_mag = unit_req.b[VALUE_WIDTH-1] ? (~unit_req.b + VALUE_WIDTH'(1)) : unit_req.b;

   // Division shifts the next dividend bit into the remainder and trial-subtracts;
   // multiplication adds the shifted multiplicand. Both use the same adder.
   assign rem_shift = {acc_ff[VALUE_WIDTH-2:0], work_ff[VALUE_WIDTH-1]};
   assign add_x     = is_div_ff ? rem_shift : acc_ff;
   assign add_y     = is_div_ff ? ~opd_ff : opd_ff;
   assign add_sum   = {1'b0, add_x} + {1'b0, add_y} + (VALUE_WIDTH+1)'(is_div_ff);
   assign ge        = add_sum[VALUE_WIDTH];

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      is_div_in = is_div_ff;
      negate_in = negate_ff;
      done_in   = 1'b0;
      acc_in    = acc_ff;
      work_in   = work_ff;
      opd_in    = opd_ff;
      case (state_ff)
         U_IDLE: begin
            if (unit_req.start) begin
               state_in  = U_RUN;
               count_in  = '0;
               is_div_in = unit_req.is_div;
               acc_in    = '0;
               negate_in = unit_req.a[VALUE_WIDTH-1] ^ unit_req.b[VALUE_WIDTH-1];
               if (unit_req.is_div) begin
                  work_in = a_mag;
                  opd_in  = b_mag;
               end else begin
                  work_in = unit_req.b;
                  opd_in  = unit_req.a;
               end
            end
         end
         U_RUN: begin
            if (is_div_ff) begin
               acc_in  = ge ? add_sum[VALUE_WIDTH-1:0] : rem_shift;
               work_in = {work_ff[VALUE_WIDTH-2:0], ge};
            end else begin
               if (work_ff[0]) begin
                  acc_in = add_sum[VALUE_WIDTH-1:0];
               end
               work_in = work_ff >> 1;
               opd_in  = opd_ff << 1;
            end
            count_in = count_ff + CNT_WIDTH'(1);
            if (count_ff == CNT_WIDTH'(VALUE_WIDTH - 1)) begin
               state_in = U_FIN;
            end
         end
         U_FIN: begin
            if (is_div_ff) begin
               acc_in = negate_ff ? (~work_ff + VALUE_WIDTH'(1)) : work_ff;
            end
            done_in  = 1'b1;
            state_in = U_IDLE;
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      count_ff  <= count_in;
      is_div_ff <= is_div_in;
      negate_ff <= negate_in;
      acc_ff    <= acc_in;
      work_ff   <= work_in;
      opd_ff    <= opd_in;
   end

   assign unit_rsp.done  = done_ff;
   assign unit_rsp.value = acc_ff;

endmodule

// File: hw/rtl/integer_expression_evaluator_core.sv
// Top level of the integer expression evaluator: token sequencer and result register.
// Depends on iee_pkg, iee_muldiv and assert_macros.svh.

// Evaluates an infix expression of non-negative operands and + - * / tokens, with
// multiply and divide binding tighter, left to right, wrapping on 32 bits and
// truncating division toward zero. Each request is one token; an end token yields
// one response with the value and a status (0 ok, 1 division by zero, 2 bad token
// order or unknown code; value 0 on error) and clears the evaluator. Operator
// tokens, plain operands and the end token do not hold up the next request. An
// operand that follows * or / goes through the shared shift-add / restoring-divide
// unit, one bit per cycle, and the block takes no new request until the unit is
// done. A divide by zero is flagged at once without using the unit. An end token
// also waits while an earlier response is still held by the receiver.
module integer_expression_evaluator_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [iee_pkg::COMMAND_WIDTH-1:0] req_command,
   input  logic [iee_pkg::OPERAND_WIDTH-1:0] req_operand_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [iee_pkg::RESULT_WIDTH-1:0] rsp_result_value,
   output logic [iee_pkg::STATUS_WIDTH-1:0]  rsp_status
);
   import iee_pkg::*;

`include "assert_macros.svh"

   typedef enum logic {S_IDLE, S_BUSY} state_type;

   state_type              state_ff, state_in;
   logic [VALUE_WIDTH-1:0] sum_ff, sum_in;
   logic [VALUE_WIDTH-1:0] term_ff, term_in;
   logic                   neg_ff, neg_in;
   mulop_type              mulop_ff, mulop_in;
   logic                   expect_ff, expect_in;
   status_type             err_ff, err_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RESULT_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   status_type             rsp_status_ff, rsp_status_in;

   logic                   req_accept;
   logic [VALUE_WIDTH-1:0] operand;
   logic [VALUE_WIDTH-1:0] total;
   status_type             end_status;
   unit_req_type           unit_req;
   unit_rsp_type           unit_rsp;

   function automatic status_type flag_error(status_type cur, status_type code);
      flag_error = (cur == ST_OK) ? code : cur;
   endfunction

   assign operand    = VALUE_WIDTH'(req_operand_value);
   // Running sum plus the signed pending term, negation folded into the carry-in.
   assign total      = sum_ff + (neg_ff ? ~term_ff : term_ff) + VALUE_WIDTH'(neg_ff);
   assign end_status = expect_ff ? flag_error(err_ff, ST_MALFORMED) : err_ff;

   assign req_stall  = (state_ff != S_IDLE) ||
                       (rsp_valid_ff && rsp_stall && (req_command == CMD_END));
   assign req_accept = req_valid && !req_stall;

   assign unit_req.start  = req_accept && (cmd_type'(req_command) == CMD_OPERAND) &&
                            expect_ff && ((mulop_ff == OP_MUL) ||
                            ((mulop_ff == OP_DIV) && (operand != '0)));
   assign unit_req.is_div = (mulop_ff == OP_DIV);
   assign unit_req.a      = term_ff;
   assign unit_req.b      = operand;

   iee_muldiv u_muldiv (
      .clock    (clock),
      .reset    (reset),
      .unit_req (unit_req),
      .unit_rsp (unit_rsp)
   );

   always_comb begin
      state_in      = state_ff;
      sum_in        = sum_ff;
      term_in       = term_ff;
      neg_in        = neg_ff;
      mulop_in      = mulop_ff;
      expect_in     = expect_ff;
      err_in        = err_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;

      if (state_ff == S_BUSY) begin
         if (unit_rsp.done) begin
            term_in   = unit_rsp.value;
            mulop_in  = OP_NONE;
            expect_in = 1'b0;
            state_in  = S_IDLE;
         end
      end else if (req_accept) begin
         case (cmd_type'(req_command))
            CMD_OPERAND: begin
               if (!expect_ff) begin
                  err_in = flag_error(err_ff, ST_MALFORMED);
               end else if (unit_req.start) begin
                  state_in = S_BUSY;
               end else begin
                  if (mulop_ff == OP_DIV) begin
                     err_in = flag_error(err_ff, ST_DIVZERO);
                  end else begin
                     term_in = operand;
                  end
                  mulop_in  = OP_NONE;
                  expect_in = 1'b0;
               end
            end
            CMD_ADD, CMD_SUB: begin
               if (expect_ff) begin
                  err_in = flag_error(err_ff, ST_MALFORMED);
               end else begin
                  sum_in    = total;
                  term_in   = '0;
                  neg_in    = (cmd_type'(req_command) == CMD_SUB);
                  expect_in = 1'b1;
               end
            end
            CMD_MUL, CMD_DIV: begin
               if (expect_ff) begin
                  err_in = flag_error(err_ff, ST_MALFORMED);
               end else begin
                  mulop_in  = (cmd_type'(req_command) == CMD_MUL) ? OP_MUL : OP_DIV;
                  expect_in = 1'b1;
               end
            end
            CMD_END: begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = end_status;
               rsp_value_in  = (end_status == ST_OK) ?
                               RESULT_WIDTH'($signed(total)) : '0;
               sum_in        = '0;
               term_in       = '0;
               neg_in        = 1'b0;
               mulop_in      = OP_NONE;
               expect_in     = 1'b1;
               err_in        = ST_OK;
            end
            default: begin
               err_in = flag_error(err_ff, ST_MALFORMED);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         term_ff      <= '0;
         neg_ff       <= 1'b0;
         mulop_ff     <= OP_NONE;
         expect_ff    <= 1'b1;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         term_ff      <= term_in;
         neg_ff       <= neg_in;
         mulop_ff     <= mulop_in;
         expect_ff    <= expect_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

   `ASSERT_IMPLIES(a_busy_stalls, clock, reset, state_ff == S_BUSY, req_stall)
   `ASSERT_IMPLIES(a_done_when_busy, clock, reset, unit_rsp.done, state_ff == S_BUSY)
   `ASSERT_IMPLIES(a_error_zero_value, clock, reset,
      rsp_valid_ff && (rsp_status_ff != ST_OK), rsp_value_ff == '0)
   `ASSERT_NEXT(a_first_error_sticks, clock, reset,
      (err_ff != ST_OK) && !(req_accept && (req_command == CMD_END)), err_ff == $past(err_ff))

endmodule

// File: tb/integer_expression_evaluator_core_tb.sv
// Self-checking testbench for integer_expression_evaluator_core: token streams of
// directed and random expressions, results checked against an in-bench evaluator.
// Depends on iee_pkg and the RTL of the core; it reads no files.
module integer_expression_evaluator_core_tb;
   import iee_pkg::*;

   localparam logic [COMMAND_WIDTH-1:0] CMD_UNUSED_SIX   = 3'd6;
   localparam logic [COMMAND_WIDTH-1:0] CMD_UNUSED_SEVEN = 3'd7;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES    = 80;
   localparam int ITEMS_PER_PHASE  = 200;

   typedef struct {
      logic [COMMAND_WIDTH-1:0] command;
      logic [OPERAND_WIDTH-1:0] operand;
      logic                     pause;
   } token_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [COMMAND_WIDTH-1:0] req_command = '0;
   logic [OPERAND_WIDTH-1:0] req_operand_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [RESULT_WIDTH-1:0] rsp_result_value;
   logic [STATUS_WIDTH-1:0] rsp_status;

   integer_expression_evaluator_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_operand_value (req_operand_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_value  (rsp_result_value),
      .rsp_status        (rsp_status)
   );

   token_type pending_tokens[$];
   logic [RESULT_WIDTH-1:0] expected_values[$];
   status_type expected_status[$];

   // Evaluator state, mirroring the block.
   logic [VALUE_WIDTH-1:0] sum_acc;
   logic [VALUE_WIDTH-1:0] term_acc;
   logic term_neg;
   mulop_type term_op;
   logic want_operand;
   status_type eval_err;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_asked = 0;
   int hold_seen = 0;
   int hold_left = 0;
   logic req_taken = 1'b0;
   logic sender_paused = 1'b0;
   int tokens_queued = 0;
   int tokens_accepted = 0;
   int results_checked = 0;
   int status_seen[3] = '{0, 0, 0};
   int mismatch_count = 0;
   int error_count = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic void clear_evaluator();
      sum_acc = '0;
      term_acc = '0;
      term_neg = 1'b0;
      term_op = OP_NONE;
      want_operand = 1'b1;
      eval_err = ST_OK;
   endfunction

   function automatic void note_error(status_type code);
      if (eval_err == ST_OK) eval_err = code;
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] signed_term();
      return term_neg ? -term_acc : term_acc;
   endfunction

   // Advances the evaluator by one token; an end token yields an expected result.
   function automatic void evaluate_token(logic [COMMAND_WIDTH-1:0] cmd,
                                          logic [OPERAND_WIDTH-1:0] opv);
      logic [VALUE_WIDTH-1:0] v;
      logic [VALUE_WIDTH-1:0] total;
      v = {1'b0, opv};
      case (cmd)
         CMD_OPERAND: begin
            if (!want_operand) begin
               note_error(ST_MALFORMED);
            end else begin
               case (term_op)
                  OP_MUL: term_acc = term_acc * v;
                  OP_DIV: begin
                     if (v == '0) note_error(ST_DIVZERO);
                     else term_acc = $signed(term_acc) / $signed(v);
                  end
                  default: term_acc = v;
               endcase
               term_op = OP_NONE;
               want_operand = 1'b0;
            end
         end
         CMD_ADD, CMD_SUB: begin
            if (want_operand) begin
               note_error(ST_MALFORMED);
            end else begin
               sum_acc = sum_acc + signed_term();
               term_acc = '0;
               term_neg = (cmd == CMD_SUB);
               want_operand = 1'b1;
            end
         end
         CMD_MUL, CMD_DIV: begin
            if (want_operand) begin
               note_error(ST_MALFORMED);
            end else begin
               term_op = (cmd == CMD_MUL) ? OP_MUL : OP_DIV;
               want_operand = 1'b1;
            end
         end
         CMD_END: begin
            if (want_operand) note_error(ST_MALFORMED);
            total = sum_acc + signed_term();
            expected_values.push_back(eval_err == ST_OK ? total : '0);
            expected_status.push_back(eval_err);
            clear_evaluator();
         end
         default: note_error(ST_MALFORMED);
      endcase
   endfunction

   function automatic void queue_token(logic [COMMAND_WIDTH-1:0] cmd,
                                       logic [OPERAND_WIDTH-1:0] opv);
      token_type t;
      t.command = cmd;
      t.operand = opv;
      t.pause = 1'b0;
      pending_tokens.push_back(t);
      tokens_queued++;
   endfunction

   function automatic logic [OPERAND_WIDTH-1:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return '0;
         1, 2, 3, 4: return OPERAND_WIDTH'($urandom_range(1, 15));
         5, 6: return OPERAND_WIDTH'($urandom_range(1, 65535));
         7, 8: return OPERAND_WIDTH'($urandom);
         default: return {OPERAND_WIDTH{1'b1}};
      endcase
   endfunction

   function automatic logic [COMMAND_WIDTH-1:0] pick_operator();
      case ($urandom_range(0, 3))
         0: return CMD_ADD;
         1: return CMD_SUB;
         2: return CMD_MUL;
         default: return CMD_DIV;
      endcase
   endfunction

   // Mostly well-formed expressions; some carry stray tokens or lose their last operand.
   function automatic void queue_expression();
      int n_operands;
      bit broken;
      token_type marker;
      n_operands = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
      broken = ($urandom_range(0, 99) < 15);
      for (int i = 0; i < n_operands; i++) begin
         if (broken && $urandom_range(0, 3) == 0)
            queue_token(COMMAND_WIDTH'($urandom_range(0, 7)), OPERAND_WIDTH'($urandom));
         if (i > 0) queue_token(pick_operator(), OPERAND_WIDTH'($urandom));
         if (!(broken && i == n_operands - 1 && $urandom_range(0, 2) == 0))
            queue_token(CMD_OPERAND, pick_operand());
      end
      queue_token(CMD_END, OPERAND_WIDTH'($urandom));
      if ($urandom_range(0, 19) == 0) begin
         marker.command = CMD_END;
         marker.operand = '0;
         marker.pause = 1'b1;
         pending_tokens.push_back(marker);
      end
   endfunction

   task automatic wait_until_idle();
      while (pending_tokens.size() != 0 || req_valid || sender_paused ||
             expected_values.size() != 0)
         @(posedge clock);
   endtask

   // Sender: a request stays offered until it is taken; idling is decided only between requests.
   always @(negedge clock) begin : request_driver
      logic nv;
      logic [COMMAND_WIDTH-1:0] nc;
      logic [OPERAND_WIDTH-1:0] no;
      token_type t;
      if (!reset) begin
         nv = req_valid;
         nc = req_command;
         no = req_operand_value;
         if (!req_valid || req_taken) begin
            nv = 1'b0;
            if (sender_paused) begin
               if (expected_values.size() == 0) sender_paused = 1'b0;
            end else if (pending_tokens.size() != 0 &&
                         $urandom_range(0, 99) >= send_idle_pct) begin
               t = pending_tokens.pop_front();
               if (t.pause) begin
                  sender_paused = 1'b1;
               end else begin
                  nv = 1'b1;
                  nc = t.command;
                  no = t.operand;
               end
            end
         end
         req_valid <= nv;
         req_command <= nc;
         req_operand_value <= no;
      end
   end

   // Receiver: random stalls, plus one long hold-off on request from the stimulus.
   always @(negedge clock) begin
      if (hold_asked != hold_seen) begin
         hold_seen = hold_asked;
         hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin : result_monitor
      logic [RESULT_WIDTH-1:0] want_value;
      status_type want_status;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            evaluate_token(req_command, req_operand_value);
            tokens_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_values.size() == 0) begin
               error_count++;
               if (mismatch_count < 10)
                  $display("ERROR: unexpected result value=%0d status=%0d",
                           rsp_result_value, rsp_status);
               mismatch_count++;
            end else begin
               want_value = expected_values.pop_front();
               want_status = expected_status.pop_front();
               results_checked++;
               if (want_status <= ST_MALFORMED) status_seen[want_status]++;
               if (rsp_result_value !== $signed(want_value) || rsp_status !== want_status) begin
                  error_count++;
                  if (mismatch_count < 10)
                     $display({"ERROR: result %0d: expected value=%0d status=%0d,",
                               " got value=%0d status=%0d"},
                              results_checked, $signed(want_value), want_status,
                              rsp_result_value, rsp_status);
                  mismatch_count++;
               end
            end
         end
      end
   end

   initial begin
      clear_evaluator();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty expression.
      queue_token(CMD_END, {OPERAND_WIDTH{1'b1}});
      // Largest operand plus one wraps to the most negative value.
      queue_token(CMD_OPERAND, {OPERAND_WIDTH{1'b1}});
      queue_token(CMD_ADD, '0);
      queue_token(CMD_OPERAND, 31'd1);
      queue_token(CMD_END, '0);
      // A product that wraps negative, then a division that truncates toward zero.
      queue_token(CMD_OPERAND, 31'd1073741825);
      queue_token(CMD_MUL, '0);
      queue_token(CMD_OPERAND, 31'd3);
      queue_token(CMD_DIV, '0);
      queue_token(CMD_OPERAND, 31'd2);
      queue_token(CMD_SUB, '0);
      queue_token(CMD_OPERAND, '0);
      queue_token(CMD_END, '0);
      // Division by zero followed by a trailing operator: the first error is kept.
      queue_token(CMD_OPERAND, 31'd5);
      queue_token(CMD_DIV, '0);
      queue_token(CMD_OPERAND, '0);
      queue_token(CMD_ADD, '0);
      queue_token(CMD_END, '0);
      // Leading operator, two operands in a row, unknown codes, trailing operator.
      queue_token(CMD_SUB, '0);
      queue_token(CMD_OPERAND, 31'd3);
      queue_token(CMD_OPERAND, 31'd3);
      queue_token(CMD_UNUSED_SIX, '0);
      queue_token(CMD_UNUSED_SEVEN, '0);
      queue_token(CMD_MUL, '0);
      queue_token(CMD_END, '0);
      wait_until_idle();

      // No idling, with one long receiver hold-off so that the input backs up.
      while (tokens_queued < 25 + ITEMS_PER_PHASE) queue_expression();
      hold_asked++;
      wait_until_idle();

      send_idle_pct = 55;
      while (tokens_queued < 25 + 2 * ITEMS_PER_PHASE) queue_expression();
      wait_until_idle();

      send_idle_pct = 0;
      recv_stall_pct = 55;
      while (tokens_queued < 25 + 3 * ITEMS_PER_PHASE) queue_expression();
      wait_until_idle();

      send_idle_pct = 35;
      recv_stall_pct = 35;
      while (tokens_queued < 25 + 4 * ITEMS_PER_PHASE) queue_expression();
      wait_until_idle();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_values.size() != 0) begin
         error_count += expected_values.size();
         $display("ERROR: %0d results never arrived", expected_values.size());
      end
      $display("Ran %0d tokens through four sender/receiver idling mixes; %0d results checked",
               tokens_accepted, results_checked);
      $display("Statuses seen: %0d ok, %0d divide by zero, %0d malformed; %0d mismatches",
               status_seen[0], status_seen[1], status_seen[2], mismatch_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/iee_pkg.sv
hw/rtl/iee_muldiv.sv
hw/rtl/integer_expression_evaluator_core.sv
tb/integer_expression_evaluator_core_tb.sv
